### hw/rtl/gww_pkg.sv
// ----------------------------------------------------------------------------
// gww_pkg: shared types and constants for the greedy word wrap block
// Payload structs, character codes, result kinds and the width lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package gww_pkg;

   // Field widths fixed by the interface
   localparam int unsigned CP_BITS       = 21;
   localparam int unsigned KIND_BITS     = 2;
   localparam int unsigned OFF_PORT_BITS = 16;
   localparam int unsigned WRAP_BITS     = 10;

   // Defaults for the top-level parameters
   localparam int unsigned DEF_MAX_WRAP_WIDTH = 1023;
   localparam int unsigned DEF_OFFSET_BITS    = 16;

   // Wrap column after reset
   localparam int unsigned WRAP_RESET = 80;

   // Most results one character can cause
   localparam int unsigned MAX_RESULTS = 2;

   // Character codes
   localparam logic [CP_BITS-1:0] CH_TAB      = 21'h00009;
   localparam logic [CP_BITS-1:0] CH_NL       = 21'h0000A;
   localparam logic [CP_BITS-1:0] CH_CR       = 21'h0000D;
   localparam logic [CP_BITS-1:0] CH_SPACE    = 21'h00020;
   localparam logic [CP_BITS-1:0] CH_COMB_LO  = 21'h00300;
   localparam logic [CP_BITS-1:0] CH_COMB_HI  = 21'h0036F;
   localparam logic [CP_BITS-1:0] CH_ZWSP     = 21'h0200B;
   localparam logic [CP_BITS-1:0] CH_BOM      = 21'h0FEFF;

   // Result kinds
   localparam logic [KIND_BITS-1:0] KIND_APPEND  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_NEWLINE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_REPLACE = 2'd2;

   typedef struct packed {
      logic [CP_BITS-1:0] code_point;
      logic               first_of_text;
   } req_type;

   typedef struct packed {
      logic [CP_BITS-1:0]       out_char;
      logic [KIND_BITS-1:0]     kind;
      logic [OFF_PORT_BITS-1:0] back_offset;
      logic                     last;
   } rsp_type;

   // Results of one character handed from the core to the output buffer
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // Display width of one character: 0 or 1
   function automatic logic char_width(input logic [CP_BITS-1:0] c);
      logic w;
      w = 1'b1;
      if (c == CH_TAB) begin
         w = 1'b1;
      end else if (c < CH_SPACE) begin
         w = 1'b0;
      end else if (c >= CH_COMB_LO && c <= CH_COMB_HI) begin
         w = 1'b0;
      end else if (c == CH_ZWSP || c == CH_BOM) begin
         w = 1'b0;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/gww_core.sv
// ----------------------------------------------------------------------------
// gww_core: line state and wrap decision
// Holds the running line state and computes, for the registered character,
// the results it causes and the next line state in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_core #(
   parameter int unsigned MAX_WRAP_WIDTH = gww_pkg::DEF_MAX_WRAP_WIDTH,
   parameter int unsigned OFFSET_BITS    = gww_pkg::DEF_OFFSET_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 fire,
   input  wire gww_pkg::req_type                     item,
   input  wire logic [$clog2(MAX_WRAP_WIDTH+2)-1:0]  lim,
   output gww_pkg::push_type                         push
);

   localparam int unsigned COL_BITS = $clog2(MAX_WRAP_WIDTH + 2);
   localparam int unsigned CNT_BITS = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
   localparam logic [CNT_BITS-1:0] CNT_LIMIT = '1;

   logic [COL_BITS-1:0] col_ff, col_in, col_e;
   logic [COL_BITS-1:0] was_ff, was_in, was_e;
   logic [CNT_BITS-1:0] cas_ff, cas_in, cas_e;
   logic                held_ff, held_in, held_e;
   logic                has_ff, has_in, has_e;

   logic                                is_sp;
   logic                                cw;
   logic [gww_pkg::CP_BITS-1:0]         ch;

   assign ch = item.code_point;

   // Next line state and results for the current character
   always_comb begin
      // a new text starts from a clean line
      col_e  = item.first_of_text ? '0 : col_ff;
      was_e  = item.first_of_text ? '0 : was_ff;
      cas_e  = item.first_of_text ? '0 : cas_ff;
      held_e = item.first_of_text ? 1'b0 : held_ff;
      has_e  = item.first_of_text ? 1'b0 : has_ff;

      col_in  = col_e;
      was_in  = was_e;
      cas_in  = cas_e;
      held_in = held_e;
      has_in  = has_e;

      is_sp = (ch == gww_pkg::CH_SPACE) || (ch == gww_pkg::CH_TAB);
      cw    = gww_pkg::char_width(ch);

      push.count               = 2'd0;
      push.first.out_char      = ch;
      push.first.kind          = gww_pkg::KIND_APPEND;
      push.first.back_offset   = '0;
      push.first.last          = 1'b1;
      push.second.out_char     = gww_pkg::CH_NL;
      push.second.kind         = gww_pkg::KIND_NEWLINE;
      push.second.back_offset  = '0;
      push.second.last         = 1'b1;

      if (ch == gww_pkg::CH_CR) begin
         // drop carriage returns
         push.count = 2'd0;
      end else if (ch == gww_pkg::CH_NL) begin
         // pass newline through and start a fresh line
         push.count = 2'd1;
         col_in  = '0;
         was_in  = '0;
         cas_in  = '0;
         held_in = 1'b0;
         has_in  = 1'b0;
      end else begin
         push.count = 2'd1;

         // track the latest eligible break space
         if (is_sp) begin
            held_in = has_e;
            cas_in  = '0;
            was_in  = '0;
         end else if (held_e) begin
            if (cas_e == CNT_LIMIT) begin
               held_in = 1'b0;
            end else begin
               cas_in = cas_e + CNT_BITS'(1);
               was_in = was_e + COL_BITS'(cw);
            end
         end
         has_in = 1'b1;
         col_in = col_e + COL_BITS'(cw);

         // break the line once it runs past the column
         if (col_in > lim) begin
            push.count       = 2'd2;
            push.first.last  = 1'b0;
            if (held_in) begin
               push.second.kind        = gww_pkg::KIND_REPLACE;
               push.second.back_offset = gww_pkg::OFF_PORT_BITS'(cas_in);
               col_in = was_in;
               has_in = (cas_in != '0);
            end else begin
               col_in = '0;
               has_in = 1'b0;
            end
            held_in = 1'b0;
            cas_in  = '0;
            was_in  = '0;
         end
      end
   end

   // Commit line state when the character moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         was_ff  <= '0;
         cas_ff  <= '0;
         held_ff <= 1'b0;
         has_ff  <= 1'b0;
      end else if (fire) begin
         col_ff  <= col_in;
         was_ff  <= was_in;
         cas_ff  <= cas_in;
         held_ff <= held_in;
         has_ff  <= has_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/gww_out_buf.sv
// ----------------------------------------------------------------------------
// gww_out_buf: two-entry result buffer
// Takes up to two results from the core in one cycle and presents them one
// transfer at a time on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire gww_pkg::push_type push,
   output logic [1:0]             free,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output gww_pkg::rsp_type       rsp_item
);

   localparam logic [1:0] DEPTH = 2'(gww_pkg::MAX_RESULTS);

   logic [1:0]       count_ff, count_in;
   gww_pkg::rsp_type slot0_ff, slot0_in;
   gww_pkg::rsp_type slot1_ff, slot1_in;

   logic       pop;
   logic [1:0] rem;
   logic [1:0] add;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = slot0_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign rem       = count_ff - {1'b0, pop};
   assign free      = DEPTH - rem;
   assign add       = fire ? push.count : 2'd0;
   assign count_in  = rem + add;

   // Shift out the head, then append new results behind what remains
   always_comb begin
      unique case (rem)
         2'd0: begin
            slot0_in = push.first;
            slot1_in = push.second;
         end
         2'd1: begin
            slot0_in = pop ? slot1_ff : slot0_ff;
            slot1_in = push.first;
         end
         default: begin
            slot0_in = slot0_ff;
            slot1_in = slot1_ff;
         end
      endcase
   end

   // Hold count under reset; payload needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

### hw/rtl/greedy_word_wrap.sv
// ----------------------------------------------------------------------------
// greedy_word_wrap: greedy line wrapping over a code point stream
// Registers each character, decides append / break in one pass and queues
// the results for the output channel. One control register sets the column.
// ----------------------------------------------------------------------------
//
//   channel  ports                          flow control   payload
//   req      req_valid/req_stall/req_item   valid, stall   code_point, first_of_text
//   rsp      rsp_valid/rsp_stall/rsp_item   valid, stall   out_char, kind, back_offset, last
//   csr      csr_valid/csr_ready/csr_data   valid, ready   wrap_width
//
// A character enters the input register, is processed there by the core and
// its results are queued in the output buffer, from which they are offered.
// One transfer per cycle when each character causes one result and the
// result channel does not stall; a line break adds a second result.
// Reset clears line state, sets the column to 80 and empties both stages.
// A stalled result channel backs up through the buffer into req_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_word_wrap #(
   parameter int unsigned MAX_WRAP_WIDTH = gww_pkg::DEF_MAX_WRAP_WIDTH,
   parameter int unsigned OFFSET_BITS    = gww_pkg::DEF_OFFSET_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire gww_pkg::req_type                req_item,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output gww_pkg::rsp_type                     rsp_item,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [gww_pkg::WRAP_BITS-1:0]   csr_data
);

   localparam int unsigned COL_BITS  = $clog2(MAX_WRAP_WIDTH + 2);
   localparam int unsigned CMP_BITS  = (COL_BITS > gww_pkg::WRAP_BITS) ?
                                       COL_BITS : gww_pkg::WRAP_BITS;
   localparam logic [COL_BITS-1:0] LIM_RESET =
      COL_BITS'((gww_pkg::WRAP_RESET > MAX_WRAP_WIDTH) ?
                MAX_WRAP_WIDTH : gww_pkg::WRAP_RESET);
   localparam logic [CMP_BITS-1:0] MAX_CMP = CMP_BITS'(MAX_WRAP_WIDTH);

   logic                in_valid_ff, in_valid_in;
   gww_pkg::req_type    in_item_ff;
   logic [COL_BITS-1:0] lim_ff, lim_in;
   logic [CMP_BITS-1:0] wrap_ext;
   gww_pkg::push_type   push;
   logic [1:0]          free;
   logic                fire;
   logic                req_take;

   // Clamp the written column into 1 .. MAX_WRAP_WIDTH
   assign csr_ready = 1'b1;
   assign wrap_ext  = CMP_BITS'(csr_data);

   always_comb begin
      priority if (wrap_ext == '0) begin
         lim_in = COL_BITS'(1);
      end else if (wrap_ext > MAX_CMP) begin
         lim_in = COL_BITS'(MAX_CMP);
      end else begin
         lim_in = COL_BITS'(wrap_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LIM_RESET;
      end else if (csr_valid && csr_ready) begin
         lim_ff <= lim_in;
      end
   end

   // Advance the held character when its results fit in the buffer
   assign fire        = in_valid_ff && (push.count <= free);
   assign req_stall   = in_valid_ff && !fire;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   gww_core #(
      .MAX_WRAP_WIDTH (MAX_WRAP_WIDTH),
      .OFFSET_BITS    (OFFSET_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_item_ff),
      .lim   (lim_ff),
      .push  (push)
   );

   gww_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .push      (push),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

### verif/tb_greedy_word_wrap.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_greedy_word_wrap: self-checking bench for the greedy word wrap block
// Feeds code point streams through the request channel and predicts every
// append, hard newline and replace edit with a scoreboard model kept beside
// the block. Runs directed corner cases, then randomized text under several
// wrap columns and flow-control patterns.
// ----------------------------------------------------------------------------

module tb_greedy_word_wrap;

   typedef logic [gww_pkg::CP_BITS-1:0]   cp_type;
   typedef logic [gww_pkg::WRAP_BITS-1:0] wrap_type;

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned MAX_PRINTED   = 40;
   localparam int unsigned PHASE_ITEMS   = 110;
   localparam int unsigned WIDE_ITEMS    = 300;
   localparam int unsigned NUM_PHASES    = 8;

   // Distance at which a held space is given up
   localparam logic [gww_pkg::OFF_PORT_BITS-1:0] BACK_LIMIT = 16'hFFFF;

   localparam cp_type CH_LOW_A  = 21'h00061;
   localparam cp_type CH_LOW_B  = 21'h00062;
   localparam cp_type CH_LOW_X  = 21'h00078;
   localparam cp_type CH_CAP_A  = 21'h00041;
   localparam cp_type CH_CAP_B  = 21'h00042;
   localparam cp_type CH_NUL    = 21'h00000;
   localparam cp_type CH_TOP    = 21'h1FFFFF;
   localparam cp_type CH_UNI_HI = 21'h10FFFF;

   // Wrap column and flow-control pattern of each random phase
   localparam wrap_type PHASE_WRAP [NUM_PHASES] =
      '{10'd1, 10'd3, 10'd7, 10'd12, 10'd1023, 10'd2, 10'd23, 10'd80};
   localparam int unsigned SEND_IDLE  [4] = '{0, 57, 0, 29};
   localparam int unsigned RECV_STALL [4] = '{0, 0, 57, 29};

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   gww_pkg::req_type req_item  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   gww_pkg::rsp_type rsp_item;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   wrap_type         csr_data  = '0;

   gww_pkg::req_type pending_chars[$];
   gww_pkg::rsp_type wrap_expected[$];
   gww_pkg::rsp_type want_rsp;
   int unsigned      send_idle_pct = 0;
   int unsigned      stall_pct     = 0;
   int unsigned      fail_count    = 0;
   int unsigned      cycle_count   = 0;

   // Scoreboard copy of the block's register and line state
   wrap_type                          wrap_col = wrap_type'(gww_pkg::WRAP_RESET);
   logic [10:0]                       line_col;
   logic [10:0]                       width_tail;
   logic [gww_pkg::OFF_PORT_BITS-1:0] chars_tail;
   logic                              break_space;
   logic                              line_busy;

   greedy_word_wrap u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Display width: tab is one column, controls and invisible marks none
   function automatic logic glyph_width(input cp_type c);
      logic w;
      w = 1'b1;
      if (c != gww_pkg::CH_TAB) begin
         if (c < gww_pkg::CH_SPACE ||
             (c >= gww_pkg::CH_COMB_LO && c <= gww_pkg::CH_COMB_HI) ||
             c == gww_pkg::CH_ZWSP || c == gww_pkg::CH_BOM) begin
            w = 1'b0;
         end
      end
      return w;
   endfunction

   function automatic cp_type pick_zero_width();
      cp_type c;
      case ($urandom_range(3))
         0: c = cp_type'($urandom_range(gww_pkg::CH_COMB_LO, gww_pkg::CH_COMB_HI));
         1: c = gww_pkg::CH_ZWSP;
         2: c = gww_pkg::CH_BOM;
         default: begin
            c = cp_type'($urandom_range(0, 31));
            if (c == gww_pkg::CH_NL || c == gww_pkg::CH_CR || c == gww_pkg::CH_TAB) begin
               c = CH_NUL;
            end
         end
      endcase
      return c;
   endfunction

   task automatic clear_line_state;
      line_col    = '0;
      width_tail  = '0;
      chars_tail  = '0;
      break_space = 1'b0;
      line_busy   = 1'b0;
   endtask

   // Work out the results one accepted character causes
   task automatic predict_wrap(input gww_pkg::req_type it);
      logic [10:0]      lim;
      logic             w;
      gww_pkg::rsp_type r;
      lim = (wrap_col == '0) ? 11'd1 : {1'b0, wrap_col};
      if (it.first_of_text) begin
         clear_line_state();
      end
      r.out_char    = it.code_point;
      r.kind        = gww_pkg::KIND_APPEND;
      r.back_offset = '0;
      r.last        = 1'b1;
      if (it.code_point == gww_pkg::CH_CR) begin
         // dropped, no result
      end else if (it.code_point == gww_pkg::CH_NL) begin
         wrap_expected.push_back(r);
         clear_line_state();
      end else begin
         w = glyph_width(it.code_point);
         if (it.code_point == gww_pkg::CH_SPACE || it.code_point == gww_pkg::CH_TAB) begin
            break_space = line_busy;
            chars_tail  = '0;
            width_tail  = '0;
         end else if (break_space) begin
            // forget a space that lies too far back
            if (chars_tail == BACK_LIMIT) begin
               break_space = 1'b0;
            end else begin
               chars_tail = chars_tail + 16'd1;
               width_tail = width_tail + 11'(w);
            end
         end
         line_busy = 1'b1;
         line_col  = line_col + 11'(w);
         if (line_col > lim) begin
            r.last = 1'b0;
            wrap_expected.push_back(r);
            r.out_char = gww_pkg::CH_NL;
            r.last     = 1'b1;
            if (break_space) begin
               r.kind        = gww_pkg::KIND_REPLACE;
               r.back_offset = chars_tail;
               line_col      = width_tail;
               line_busy     = (chars_tail != '0);
            end else begin
               r.kind    = gww_pkg::KIND_NEWLINE;
               line_col  = '0;
               line_busy = 1'b0;
            end
            break_space = 1'b0;
            chars_tail  = '0;
            width_tail  = '0;
         end
         wrap_expected.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what);
      fail_count++;
      // keep the log short on a badly broken build
      if (fail_count <= MAX_PRINTED) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   task automatic push_char(input cp_type cp, input logic first);
      gww_pkg::req_type it;
      it.code_point    = cp;
      it.first_of_text = first;
      pending_chars.push_back(it);
   endtask

   // Words with spaces, tabs, invisible marks, line ends and some noise
   task automatic queue_text(input int unsigned count, input int unsigned nl_pct,
                             input int unsigned first_pct);
      int unsigned k;
      int unsigned roll;
      cp_type      c;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 55) begin
            if ($urandom_range(9) == 0) begin
               c = cp_type'($urandom_range(21'h00370, CH_UNI_HI));
            end else begin
               c = cp_type'($urandom_range(21'h00061, 21'h0007A));
            end
         end else if (roll < 72) begin
            c = gww_pkg::CH_SPACE;
         end else if (roll < 76) begin
            c = gww_pkg::CH_TAB;
         end else if (roll < 80) begin
            c = pick_zero_width();
         end else if (roll < 80 + nl_pct) begin
            c = gww_pkg::CH_NL;
         end else if (roll < 82 + nl_pct) begin
            c = gww_pkg::CH_CR;
         end else begin
            c = cp_type'($urandom_range(0, CH_TOP));
         end
         push_char(c, $urandom_range(99) < first_pct);
      end
   endtask

   // Hold until every character is taken and every result is back
   task automatic drain_wrap;
      while (pending_chars.size() != 0 || req_valid || wrap_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_wrap(input wrap_type value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      wrap_col = value;
   endtask

   // Driver: present queued characters, predict on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_wrap(req_item);
         end
         if (!req_valid || !req_stall) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_item  <= pending_chars.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, check each result transfer in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (wrap_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected result char %h kind %0d",
                                         rsp_item.out_char, rsp_item.kind));
            end else begin
               want_rsp = wrap_expected.pop_front();
               if (rsp_item.out_char !== want_rsp.out_char) begin
                  report_mismatch($sformatf("out_char %h, want %h",
                                            rsp_item.out_char, want_rsp.out_char));
               end
               if (rsp_item.kind !== want_rsp.kind) begin
                  report_mismatch($sformatf("kind %0d, want %0d",
                                            rsp_item.kind, want_rsp.kind));
               end
               if (rsp_item.back_offset !== want_rsp.back_offset) begin
                  report_mismatch($sformatf("back_offset %0d, want %0d",
                                            rsp_item.back_offset, want_rsp.back_offset));
               end
               if (rsp_item.last !== want_rsp.last) begin
                  report_mismatch($sformatf("last %b, want %b",
                                            rsp_item.last, want_rsp.last));
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int unsigned p;
      clear_line_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Corner code points at the reset column
      push_char(CH_CAP_A, 1'b1);
      push_char(CH_NUL, 1'b0);
      push_char(CH_TOP, 1'b0);
      push_char(CH_UNI_HI, 1'b0);
      push_char(CH_UNI_HI + 21'd1, 1'b0);
      push_char(gww_pkg::CH_CR, 1'b0);
      push_char(gww_pkg::CH_SPACE - 21'd1, 1'b0);
      push_char(gww_pkg::CH_COMB_LO - 21'd1, 1'b0);
      push_char(gww_pkg::CH_COMB_LO, 1'b0);
      push_char(gww_pkg::CH_COMB_HI, 1'b0);
      push_char(gww_pkg::CH_COMB_HI + 21'd1, 1'b0);
      push_char(gww_pkg::CH_ZWSP, 1'b0);
      push_char(gww_pkg::CH_BOM, 1'b0);
      push_char(gww_pkg::CH_TAB, 1'b0);
      push_char(gww_pkg::CH_SPACE, 1'b0);
      push_char(gww_pkg::CH_NL, 1'b0);
      push_char(gww_pkg::CH_SPACE, 1'b0);
      push_char(CH_CAP_B, 1'b0);
      drain_wrap();

      // Column zero acts as one: hard break, space break, leading space
      write_wrap('0);
      push_char(CH_LOW_A, 1'b0);
      push_char(CH_LOW_B, 1'b0);
      push_char(CH_LOW_A, 1'b0);
      push_char(gww_pkg::CH_SPACE, 1'b0);
      push_char(gww_pkg::CH_SPACE, 1'b0);
      push_char(CH_LOW_X, 1'b0);
      push_char(CH_LOW_A, 1'b0);
      push_char(gww_pkg::CH_TAB, 1'b0);
      push_char(CH_LOW_A, 1'b0);
      push_char(CH_LOW_B, 1'b1);
      drain_wrap();

      // Random text under each column and flow-control pattern
      for (p = 0; p < NUM_PHASES; p++) begin
         write_wrap(PHASE_WRAP[p]);
         send_idle_pct = SEND_IDLE[p % 4];
         stall_pct     = RECV_STALL[p % 4];
         if (PHASE_WRAP[p] == 10'd1023) begin
            queue_text(WIDE_ITEMS, 0, 0);
         end else begin
            queue_text(PHASE_ITEMS, 4, 2);
         end
         drain_wrap();
      end

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/gww_pkg.sv
hw/rtl/gww_core.sv
hw/rtl/gww_out_buf.sv
hw/rtl/greedy_word_wrap.sv
verif/tb_greedy_word_wrap.sv
